>>> rtl/joystick_demand_controller_macros.svh
// Assertion helpers for the file that checks its own logic.
`ifndef JOYSTICK_DEMAND_CONTROLLER_MACROS_SVH
`define JOYSTICK_DEMAND_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/jdc_pkg.sv
package jdc_pkg;

    typedef enum logic [10:0] {
        M_POWERUP     = 11'b000_0000_0001,
        M_ENTER_DRIVE = 11'b000_0000_0010,
        M_DRIVE       = 11'b000_0000_0100,
        M_ENTER_BT    = 11'b000_0000_1000,
        M_BT          = 11'b000_0001_0000,
        M_ENTER_MC    = 11'b000_0010_0000,
        M_MC          = 11'b000_0100_0000,
        M_EXIT_MC     = 11'b000_1000_0000,
        M_ENTER_CAL   = 11'b001_0000_0000,
        M_CAL         = 11'b010_0000_0000,
        M_EXIT_CAL    = 11'b100_0000_0000
    } t_mode;

    localparam logic [3:0] MODE_CODE_POWERUP     = 4'd0;
    localparam logic [3:0] MODE_CODE_ENTER_DRIVE = 4'd1;
    localparam logic [3:0] MODE_CODE_DRIVE       = 4'd2;
    localparam logic [3:0] MODE_CODE_ENTER_BT    = 4'd3;
    localparam logic [3:0] MODE_CODE_BT          = 4'd4;
    localparam logic [3:0] MODE_CODE_ENTER_MC    = 4'd6;
    localparam logic [3:0] MODE_CODE_MC          = 4'd7;
    localparam logic [3:0] MODE_CODE_EXIT_MC     = 4'd8;
    localparam logic [3:0] MODE_CODE_ENTER_CAL   = 4'd9;
    localparam logic [3:0] MODE_CODE_CAL         = 4'd10;
    localparam logic [3:0] MODE_CODE_EXIT_CAL    = 4'd11;

    localparam logic [2:0] CFG_SPEED_POS = 3'd0;
    localparam logic [2:0] CFG_SPEED_NEG = 3'd1;
    localparam logic [2:0] CFG_DIR_POS   = 3'd2;
    localparam logic [2:0] CFG_DIR_NEG   = 3'd3;
    localparam logic [2:0] CFG_MARGIN    = 3'd4;
    localparam logic [2:0] CFG_MAX_DEFL  = 3'd5;

    localparam logic [15:0] STORED_SCALE_RESET = 16'd240;
    localparam logic [9:0]  LIVE_SCALE_RESET   = 10'd240;
    localparam logic [7:0]  MARGIN_RESET       = 8'd16;
    localparam logic [9:0]  MAX_DEFL_RESET     = 10'd240;

    typedef struct packed {
        logic capture;
        logic mul;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_status;

    function automatic logic [3:0] mode_to_code(input t_mode m);
        logic [3:0] c;
        unique case (m)
            M_POWERUP:     c = MODE_CODE_POWERUP;
            M_ENTER_DRIVE: c = MODE_CODE_ENTER_DRIVE;
            M_DRIVE:       c = MODE_CODE_DRIVE;
            M_ENTER_BT:    c = MODE_CODE_ENTER_BT;
            M_BT:          c = MODE_CODE_BT;
            M_ENTER_MC:    c = MODE_CODE_ENTER_MC;
            M_MC:          c = MODE_CODE_MC;
            M_EXIT_MC:     c = MODE_CODE_EXIT_MC;
            M_ENTER_CAL:   c = MODE_CODE_ENTER_CAL;
            M_CAL:         c = MODE_CODE_CAL;
            M_EXIT_CAL:    c = MODE_CODE_EXIT_CAL;
            default:       c = MODE_CODE_POWERUP;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/jdc_ctrl.sv
module jdc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jdc_pkg::t_dp_cmd    o_cmd,
    input  jdc_pkg::t_dp_status i_status
);
    import jdc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/jdc_dp.sv
module jdc_dp #(
    parameter int SAMPLE_BITS  = 10,
    parameter int NEUTRAL_CODE = 1115,
    parameter int SPAN_CODE    = 630,
    parameter int DAC_MAX      = 1700,
    parameter int DAC_MIN      = 520
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jdc_pkg::t_dp_cmd    i_cmd,
    output jdc_pkg::t_dp_status o_status,
    input  logic [9:0]          i_speed_sample,
    input  logic [9:0]          i_direction_sample,
    input  logic                i_stick_centred,
    input  logic                i_calib_button,
    input  logic                i_port_button,
    input  logic                i_mode_button,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic [10:0]         o_speed_demand,
    output logic [10:0]         o_direction_demand,
    output logic [3:0]          o_bt_lines,
    output logic                o_bluetooth_on,
    output logic                o_reset_line,
    output logic                o_buzzer_on,
    output logic                o_scales_saved,
    output logic [9:0]          o_speed_pos_out,
    output logic [9:0]          o_speed_neg_out,
    output logic [9:0]          o_dir_pos_out,
    output logic [9:0]          o_dir_neg_out,
    output logic [3:0]          o_mode_code
);
    import jdc_pkg::*;

    localparam int         SMAX     = (SAMPLE_BITS >= 31) ? 32'h7FFF_FFFF
                                                          : (1 << SAMPLE_BITS) - 1;
    localparam logic [9:0] RAW_MASK = (SMAX >= 1023) ? 10'h3FF : 10'(SMAX);
    localparam int         QB       = $clog2(SPAN_CODE + 1);
    localparam int         NW       = 10 + QB;
    localparam int         CW       = (QB > 1) ? $clog2(QB) : 1;

    function automatic logic [10:0] dac_clamp(input int d);
        int v;
        v = d;
        if (v > DAC_MAX) v = DAC_MAX;
        if (v < DAC_MIN) v = DAC_MIN;
        if (v < 0) v = 0;
        return 11'(v);
    endfunction

    function automatic logic [9:0] checked_scale(input logic [15:0] s,
                                                 input logic [9:0] md);
        logic [9:0] r;
        if (s > {6'd0, md} || s < {9'd0, md[9:3]}) r = md;
        else r = s[9:0];
        return r;
    endfunction

    logic [7:0]  r_margin;
    logic [9:0]  r_maxdef;

    t_mode       r_mode, n_mode;
    logic [9:0]  r_neutral [2], n_neutral [2];
    logic [9:0]  r_wl [2],      n_wl [2];
    logic [10:0] r_wh [2],      n_wh [2];
    logic [9:0]  r_smin [2],    n_smin [2];
    logic [9:0]  r_smax [2],    n_smax [2];
    logic [9:0]  r_pos [2],     n_pos [2];
    logic [9:0]  r_neg [2],     n_neg [2];
    logic [10:0] r_held [2],    n_held [2];
    logic [3:0]  r_bt_lvl,      n_bt_lvl;
    logic        r_bt,          n_bt;
    logic        r_rline,       n_rline;
    logic        r_beep,        n_beep;
    logic        r_saved,       n_saved;

    logic [9:0]  r_raw [2];
    logic        r_centred, r_calib, r_port, r_modeb;
    logic [9:0]  r_off [2];
    logic [9:0]  r_div [2];
    logic        r_side_neg [2];
    logic        r_neut [2];
    logic [10:0] r_rem [2];
    logic [QB-1:0] r_quo [2];
    logic [CW-1:0] r_cnt;

    logic [9:0]  raw_in [2];
    logic [9:0]  cap_off [2];
    logic [9:0]  cap_div [2];
    logic        cap_neg [2];
    logic        cap_neut [2];
    logic [NW-1:0] prod [2];
    logic [10:0] trial [2];
    logic        qbit [2];
    int          dem [2];

    assign raw_in[0] = i_speed_sample & RAW_MASK;
    assign raw_in[1] = i_direction_sample & RAW_MASK;
    assign o_status.div_last = (r_cnt == CW'(QB - 1));

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            logic [10:0] diff;
            cap_off[a]  = '0;
            cap_div[a]  = '0;
            cap_neg[a]  = 1'b0;
            cap_neut[a] = 1'b1;
            diff        = '0;
            if ({1'b0, raw_in[a]} > r_wh[a]) begin
                cap_div[a] = r_pos[a];
                if (raw_in[a] > r_neutral[a] && r_pos[a] != '0) begin
                    diff        = {1'b0, raw_in[a]} - {1'b0, r_neutral[a]};
                    cap_off[a]  = (diff > {1'b0, r_pos[a]}) ? r_pos[a] : diff[9:0];
                    cap_neut[a] = 1'b0;
                end
            end else if (raw_in[a] < r_wl[a]) begin
                cap_div[a] = r_neg[a];
                cap_neg[a] = 1'b1;
                if (raw_in[a] < r_neutral[a] && r_neg[a] != '0) begin
                    diff        = {1'b0, r_neutral[a]} - {1'b0, raw_in[a]};
                    cap_off[a]  = (diff > {1'b0, r_neg[a]}) ? r_neg[a] : diff[9:0];
                    cap_neut[a] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            prod[a]  = NW'(r_off[a]) * NW'(SPAN_CODE);
            trial[a] = {r_rem[a][9:0], r_quo[a][QB-1]};
            qbit[a]  = (trial[a] >= {1'b0, r_div[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw[0]  <= raw_in[0];
            r_raw[1]  <= raw_in[1];
            r_centred <= i_stick_centred;
            r_calib   <= i_calib_button;
            r_port    <= i_port_button;
            r_modeb   <= i_mode_button;
            for (int a = 0; a < 2; a++) begin
                r_off[a]      <= cap_off[a];
                r_div[a]      <= cap_div[a];
                r_side_neg[a] <= cap_neg[a];
                r_neut[a]     <= cap_neut[a];
            end
        end
        for (int a = 0; a < 2; a++) begin
            if (i_cmd.mul) begin
                r_rem[a] <= {1'b0, prod[a][NW-1:QB]};
                r_quo[a] <= prod[a][QB-1:0];
            end else if (i_cmd.step) begin
                r_rem[a] <= qbit[a] ? (trial[a] - {1'b0, r_div[a]}) : trial[a];
                r_quo[a] <= QB'({r_quo[a], qbit[a]});
            end
        end
        if (i_cmd.mul) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            int q;
            q = int'(r_quo[a]);
            if (r_neut[a]) begin
                dem[a] = NEUTRAL_CODE;
            end else if (r_side_neg[a]) begin
                dem[a] = NEUTRAL_CODE - q - ((r_rem[a] != '0) ? 1 : 0);
            end else begin
                dem[a] = NEUTRAL_CODE + q;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_bt_lvl = r_bt_lvl;
        n_bt     = r_bt;
        n_rline  = r_rline;
        n_beep   = r_beep;
        n_saved  = 1'b0;
        for (int a = 0; a < 2; a++) begin
            n_neutral[a] = r_neutral[a];
            n_wl[a]      = r_wl[a];
            n_wh[a]      = r_wh[a];
            n_smin[a]    = r_smin[a];
            n_smax[a]    = r_smax[a];
            n_pos[a]     = r_pos[a];
            n_neg[a]     = r_neg[a];
            n_held[a]    = r_held[a];
        end
        unique case (r_mode)
            M_POWERUP: begin
                if (r_centred) begin
                    for (int a = 0; a < 2; a++) begin
                        logic [11:0] hi;
                        hi           = {2'b0, r_raw[a]} + {4'b0, r_margin};
                        n_neutral[a] = r_raw[a];
                        n_wl[a]      = (r_raw[a] > {2'b0, r_margin})
                                       ? r_raw[a] - {2'b0, r_margin} : '0;
                        n_wh[a]      = (int'(hi) > SMAX) ? 11'(SMAX) : hi[10:0];
                    end
                    n_mode = M_ENTER_DRIVE;
                end
            end
            M_ENTER_DRIVE: begin
                n_beep = 1'b0;
                if (r_centred && !r_port && !r_calib) n_mode = M_DRIVE;
            end
            M_DRIVE: begin
                if (r_calib) n_mode = M_ENTER_CAL;
                if (r_port)  n_mode = M_ENTER_BT;
                if (r_modeb) n_mode = M_ENTER_MC;
                for (int a = 0; a < 2; a++) begin
                    n_held[a] = (r_calib || r_port || r_modeb)
                                ? dac_clamp(NEUTRAL_CODE) : dac_clamp(dem[a]);
                end
            end
            M_ENTER_BT: begin
                n_beep = r_port;
                if (!r_port) begin
                    n_bt   = 1'b1;
                    n_mode = M_BT;
                end
            end
            M_BT: begin
                if (r_port) begin
                    n_bt   = 1'b0;
                    n_mode = M_ENTER_DRIVE;
                end
                if (r_centred) begin
                    n_bt_lvl = 4'hF;
                end else begin
                    if ({1'b0, r_raw[0]} > {1'b0, r_neutral[0]} + {2'b0, r_pos[0][9:1]})
                        n_bt_lvl[0] = 1'b0;
                    else if ({1'b0, r_raw[0]} + {2'b0, r_neg[0][9:1]} < {1'b0, r_neutral[0]})
                        n_bt_lvl[1] = 1'b0;
                    if ({1'b0, r_raw[1]} > {1'b0, r_neutral[1]} + {2'b0, r_pos[1][9:1]})
                        n_bt_lvl[3] = 1'b0;
                    else if ({1'b0, r_raw[1]} + {2'b0, r_neg[1][9:1]} < {1'b0, r_neutral[1]})
                        n_bt_lvl[2] = 1'b0;
                end
            end
            M_ENTER_MC: begin
                n_rline = 1'b1;
                n_mode  = M_MC;
            end
            M_MC: begin
                if (!r_modeb) begin
                    n_mode  = M_EXIT_MC;
                    n_rline = 1'b0;
                end
            end
            M_EXIT_MC: begin
                n_mode = M_ENTER_DRIVE;
            end
            M_ENTER_CAL: begin
                n_beep = r_calib;
                if (!r_calib && r_centred) begin
                    for (int a = 0; a < 2; a++) begin
                        n_smax[a] = r_neutral[a];
                        n_smin[a] = r_neutral[a];
                    end
                    n_mode = M_CAL;
                end
            end
            M_CAL: begin
                for (int a = 0; a < 2; a++) begin
                    if (r_raw[a] > r_smax[a]) n_smax[a] = r_raw[a];
                    if (r_raw[a] < r_smin[a]) n_smin[a] = r_raw[a];
                end
                if (r_calib) begin
                    for (int a = 0; a < 2; a++) begin
                        n_pos[a] = n_smax[a] - r_neutral[a];
                        n_neg[a] = r_neutral[a] - n_smin[a];
                    end
                    n_saved = 1'b1;
                    n_beep  = 1'b1;
                    n_mode  = M_EXIT_CAL;
                end
            end
            M_EXIT_CAL: begin
                if (!r_calib) begin
                    n_beep = 1'b0;
                    n_mode = M_POWERUP;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= MARGIN_RESET;
            r_maxdef <= MAX_DEFL_RESET;
            r_mode   <= M_POWERUP;
            r_bt_lvl <= 4'hF;
            r_bt     <= 1'b0;
            r_rline  <= 1'b0;
            r_beep   <= 1'b0;
            r_saved  <= 1'b0;
            for (int a = 0; a < 2; a++) begin
                r_neutral[a] <= '0;
                r_wl[a]      <= '0;
                r_wh[a]      <= '0;
                r_smin[a]    <= '0;
                r_smax[a]    <= '0;
                r_pos[a]     <= LIVE_SCALE_RESET;
                r_neg[a]     <= LIVE_SCALE_RESET;
                r_held[a]    <= 11'(NEUTRAL_CODE);
            end
        end else if (i_cfg_we) begin
            priority if (i_cfg_index == CFG_SPEED_POS) begin
                r_pos[0] <= checked_scale(i_cfg_data, r_maxdef);
            end else if (i_cfg_index == CFG_SPEED_NEG) begin
                r_neg[0] <= checked_scale(i_cfg_data, r_maxdef);
            end else if (i_cfg_index == CFG_DIR_POS) begin
                r_pos[1] <= checked_scale(i_cfg_data, r_maxdef);
            end else if (i_cfg_index == CFG_DIR_NEG) begin
                r_neg[1] <= checked_scale(i_cfg_data, r_maxdef);
            end else if (i_cfg_index == CFG_MARGIN) begin
                r_margin <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_MAX_DEFL) begin
                r_maxdef <= i_cfg_data[9:0];
            end else begin
                r_margin <= r_margin;
            end
        end else if (i_cmd.commit) begin
            r_mode   <= n_mode;
            r_bt_lvl <= n_bt_lvl;
            r_bt     <= n_bt;
            r_rline  <= n_rline;
            r_beep   <= n_beep;
            r_saved  <= n_saved;
            for (int a = 0; a < 2; a++) begin
                r_neutral[a] <= n_neutral[a];
                r_wl[a]      <= n_wl[a];
                r_wh[a]      <= n_wh[a];
                r_smin[a]    <= n_smin[a];
                r_smax[a]    <= n_smax[a];
                r_pos[a]     <= n_pos[a];
                r_neg[a]     <= n_neg[a];
                r_held[a]    <= n_held[a];
            end
        end
    end

    assign o_speed_demand     = r_held[0];
    assign o_direction_demand = r_held[1];
    assign o_bt_lines         = r_bt_lvl;
    assign o_bluetooth_on     = r_bt;
    assign o_reset_line       = r_rline;
    assign o_buzzer_on        = r_beep;
    assign o_scales_saved     = r_saved;
    assign o_speed_pos_out    = r_pos[0];
    assign o_speed_neg_out    = r_neg[0];
    assign o_dir_pos_out      = r_pos[1];
    assign o_dir_neg_out      = r_neg[1];
    assign o_mode_code        = mode_to_code(r_mode);

endmodule

>>> rtl/joystick_demand_controller.sv
// Joystick demand controller.
// One input beat per control tick carries both ADC samples, the centred flag
// and the three buttons. Each accepted beat gives exactly one output beat
// with both held DAC demands, the Bluetooth lines, the status flags, the four
// live scales and the mode code.
// Both channels use valid and stall. The input side is stalled from the
// accepting edge until the result is loaded into the output register.
// An item runs through capture, multiply, one cycle per quotient bit of
// a restoring divider per axis (both axes in parallel, with a shared step
// counter), and commit, which waits until the output register is free.
// If the receiver stalls, the finished result waits in the output register;
// the next item is accepted and computed meanwhile and commits once the
// output beat has been taken.
// Configuration writes on the plain write port take effect at once; the user
// must make them only while the block is idle; the block does not enforce it.
// Synchronous reset puts the block in power-up neutral capture with neutral
// demands, all Bluetooth lines high, flags clear and default registers.
module joystick_demand_controller #(
    parameter int SAMPLE_BITS  = 10,
    parameter int NEUTRAL_CODE = 1115,
    parameter int SPAN_CODE    = 630,
    parameter int DAC_MAX      = 1700,
    parameter int DAC_MIN      = 520
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_speed_sample,
    input  logic [9:0]  i_direction_sample,
    input  logic        i_stick_centred,
    input  logic        i_calib_button,
    input  logic        i_port_button,
    input  logic        i_mode_button,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [10:0] o_speed_demand,
    output logic [10:0] o_direction_demand,
    output logic [3:0]  o_bt_lines,
    output logic        o_bluetooth_on,
    output logic        o_reset_line,
    output logic        o_buzzer_on,
    output logic        o_scales_saved,
    output logic [9:0]  o_speed_pos_out,
    output logic [9:0]  o_speed_neg_out,
    output logic [9:0]  o_dir_pos_out,
    output logic [9:0]  o_dir_neg_out,
    output logic [3:0]  o_mode_code,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import jdc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    jdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    jdc_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .NEUTRAL_CODE (NEUTRAL_CODE),
        .SPAN_CODE    (SPAN_CODE),
        .DAC_MAX      (DAC_MAX),
        .DAC_MIN      (DAC_MIN)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_speed_sample     (i_speed_sample),
        .i_direction_sample (i_direction_sample),
        .i_stick_centred    (i_stick_centred),
        .i_calib_button     (i_calib_button),
        .i_port_button      (i_port_button),
        .i_mode_button      (i_mode_button),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_speed_demand     (o_speed_demand),
        .o_direction_demand (o_direction_demand),
        .o_bt_lines         (o_bt_lines),
        .o_bluetooth_on     (o_bluetooth_on),
        .o_reset_line       (o_reset_line),
        .o_buzzer_on        (o_buzzer_on),
        .o_scales_saved     (o_scales_saved),
        .o_speed_pos_out    (o_speed_pos_out),
        .o_speed_neg_out    (o_speed_neg_out),
        .o_dir_pos_out      (o_dir_pos_out),
        .o_dir_neg_out      (o_dir_neg_out),
        .o_mode_code        (o_mode_code)
    );

`include "joystick_demand_controller_macros.svh"

    `JDC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `JDC_ASSERT_SAME(a_bt_only_in_bt, i_clk, i_rst_n, o_bluetooth_on, o_mode_code == MODE_CODE_BT)
    `JDC_ASSERT_SAME(a_rst_only_in_mc, i_clk, i_rst_n, o_reset_line, o_mode_code == MODE_CODE_MC)

endmodule
